// File: rtl/fpgne_pkg.sv
// Shared types, constants and tables of the fixed-point graph node executor.
package fpgne_pkg;

  localparam int FP_ONE   = 4096;
  localparam int FP_LIMIT = FP_ONE * 9;
  localparam int FRAC_W   = 12;

  // Divider sizing for the sigmoid: numerator below 2^25, divisor in 4096..8192,
  // quotient never above 4096.
  localparam int NUM_W = 25;
  localparam int DEN_W = 14;
  localparam int QUO_W = 13;
  localparam int CNT_W = 4;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_EXEC  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_IDLE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_SIGMOID = 3'd1,
    OP_MUL     = 3'd2,
    OP_NEG     = 3'd3,
    OP_ADD     = 3'd4
  } op_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  // exp(-k) steps in fixed point, k = 0..7 (the step at 8 is implied by the diff).
  function automatic logic [QUO_W-1:0] exp_step(input logic [2:0] idx);
    logic [QUO_W-1:0] v;
    case (idx)
      3'd0:    v = 13'd4096;
      3'd1:    v = 13'd1507;
      3'd2:    v = 13'd554;
      3'd3:    v = 13'd204;
      3'd4:    v = 13'd75;
      3'd5:    v = 13'd28;
      3'd6:    v = 13'd10;
      3'd7:    v = 13'd4;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

  // Drop from step k to step k+1.
  function automatic logic [FRAC_W-1:0] exp_diff(input logic [2:0] idx);
    logic [FRAC_W-1:0] v;
    case (idx)
      3'd0:    v = 12'd2589;
      3'd1:    v = 12'd953;
      3'd2:    v = 12'd350;
      3'd3:    v = 12'd129;
      3'd4:    v = 12'd47;
      3'd5:    v = 12'd18;
      3'd6:    v = 12'd6;
      3'd7:    v = 12'd3;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/fixed_point_graph_node_executor.sv
// Top level: variable file, node sequencer and output register of the graph node executor.
//
// Usage:
//   Slave channel s_*: one beat is one command. s_tuser carries the mode (write
//   variable, execute node, read variable); s_tdata carries the node fields and
//   the value to write. Master channel m_*: exactly one 32-bit result beat per
//   command (echoed write value, node result or read data).
//   The block works on one command at a time; s_tready is high only while the
//   sequencer is idle. After the accepting edge a write goes straight to the done
//   state; a read passes RD1 and RD2; negate, add and the other ops pass RD1, RD2
//   and OP; multiply adds MUL1 to MUL4; sigmoid adds SIG1 to SIG3 and waits in DIV
//   on the 13-step radix-2 divider, unless saturated (done after SIG1) or negative
//   with a zero exp term (done after SIG3). The done state loads the result and
//   s_tready returns at that edge; multiply makes two passes through the shared 32x32 multiplier.
//   The result sits in an output register, so a new command is taken while
//   the previous result still waits; if the receiver stalls, the sequencer
//   holds its next result until the output register frees up.
//   Reset clears every variable to zero at once through per-entry valid bits,
//   so commands are taken in the first cycle after reset.
module fixed_point_graph_node_executor #(
  parameter int NUM_VARS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op[2:0], first_src[8:3], second_src[14:9], second_used[15], dest[21:16],
  // write_value[53:22], zero pad[55:54]
  input  logic [55:0] s_tdata,
  // mode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // value[31:0]
  output logic [31:0] m_tdata
);

  localparam int AW = $clog2(NUM_VARS);

  typedef enum logic [3:0] {
    S_IDLE, S_RD1, S_RD2, S_OP, S_MUL1, S_MUL2, S_MUL3, S_MUL4,
    S_SIG1, S_SIG2, S_SIG3, S_DIV, S_DONE
  } state_t;

  state_t              state;
  fpgne_pkg::mode_t    mode;
  fpgne_pkg::op_t      op;
  logic [5:0]          src1;
  logic [5:0]          src2;
  logic                used2;
  logic [5:0]          dest;

  logic signed [31:0]  v1;
  logic signed [31:0]  b;
  logic signed [31:0]  whole;
  logic signed [31:0]  part;
  logic signed [31:0]  hi;
  logic signed [31:0]  acc;
  logic [15:0]         yabs;
  logic                sneg;
  logic                sbig;
  logic [fpgne_pkg::QUO_W-1:0] e;
  logic signed [31:0]  res;

  // variable file
  logic [31:0]         mem [NUM_VARS];
  logic [NUM_VARS-1:0] vld;
  logic [5:0]          rd_idx;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic [31:0]         rd_data;
  logic                rd_ok;
  logic signed [31:0]  operand;
  logic signed [31:0]  v2_now;
  logic                out_free;
  logic                we;
  logic                accept;

  // shared units
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [31:0]         mul_p;
  fpgne_pkg::div_req_t div_req;
  logic                div_done;
  logic [fpgne_pkg::QUO_W-1:0] div_quo;
  logic [fpgne_pkg::DEN_W-1:0] sig_den;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign rd_idx  = (state == S_RD1) ? src1 : src2;
  assign rd_addr = AW'(rd_idx);
  assign wr_addr = AW'(dest);
  assign operand = rd_ok ? $signed(rd_data) : 32'sd0;
  assign v2_now  = used2 ? operand : 32'sd0;

  assign we = (state == S_DONE) && out_free &&
              ((mode == fpgne_pkg::MODE_WRITE) || (mode == fpgne_pkg::MODE_EXEC)) &&
              (int'(dest) < NUM_VARS);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= res;
    end
    rd_data <= mem[rd_addr];
  end

  // Valid bits stand in for the clear at reset: an entry never written reads zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= vld[rd_addr] && (int'(rd_idx) < NUM_VARS);
      if (we) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  // Multiplier operands: whole*b, part*b, and for the sigmoid the interpolation slope*fraction.
  always_comb begin
    case (state)
      S_MUL1:  mul_a = whole;
      S_MUL2:  mul_a = part;
      default: mul_a = 32'(fpgne_pkg::exp_diff(yabs[14:12]));
    endcase
    mul_b = (state == S_SIG1) ? 32'(yabs[11:0]) : b;
  end

  fpgne_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Sigmoid division: d = 4096 + e; numerator 2^24 + d/2, or e*4096 + d/2 below zero.
  always_comb begin
    sig_den       = fpgne_pkg::DEN_W'(e) + fpgne_pkg::DEN_W'(fpgne_pkg::FP_ONE);
    div_req.start = (state == S_SIG3) && !(sneg && (e == '0));
    div_req.den   = sig_den;
    div_req.num   = (sneg ? {e, 12'd0} : fpgne_pkg::NUM_W'(25'h100_0000)) +
                    fpgne_pkg::NUM_W'(sig_den[fpgne_pkg::DEN_W-1:1]);
  end

  fpgne_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // drop the beat once taken, unless the done state reloads it this edge
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            mode  <= fpgne_pkg::mode_t'(s_tuser);
            op    <= fpgne_pkg::op_t'(s_tdata[2:0]);
            src1  <= s_tdata[8:3];
            src2  <= s_tdata[14:9];
            used2 <= s_tdata[15];
            dest  <= s_tdata[21:16];
            case (fpgne_pkg::mode_t'(s_tuser))
              fpgne_pkg::MODE_WRITE: begin
                res   <= $signed(s_tdata[53:22]);
                state <= S_DONE;
              end
              fpgne_pkg::MODE_EXEC, fpgne_pkg::MODE_READ: begin
                state <= S_RD1;
              end
              default: begin
                res   <= 32'sd0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RD1: begin
          state <= S_RD2;
        end
        S_RD2: begin
          v1 <= operand;
          if (mode == fpgne_pkg::MODE_READ) begin
            res   <= operand;
            state <= S_DONE;
          end else begin
            state <= S_OP;
          end
        end
        S_OP: begin
          b <= v2_now;
          case (op)
            fpgne_pkg::OP_NEG: begin
              res   <= 32'sd0 - v1;
              state <= S_DONE;
            end
            fpgne_pkg::OP_ADD: begin
              res   <= v1 + v2_now;
              state <= S_DONE;
            end
            fpgne_pkg::OP_MUL: begin
              // truncate toward zero: round the floor up when negative with a fraction
              whole <= (v1 >>> fpgne_pkg::FRAC_W) +
                       $signed(32'(v1[31] && (v1[11:0] != '0)));
              state <= S_MUL1;
            end
            fpgne_pkg::OP_SIGMOID: begin
              sneg  <= v1[31];
              sbig  <= (v1 >= 32'sd36864) || (v1 <= -32'sd36864);
              yabs  <= v1[31] ? 16'(32'sd0 - v1) : v1[15:0];
              state <= S_SIG1;
            end
            default: begin
              res   <= 32'sd0;
              state <= S_DONE;
            end
          endcase
        end
        S_MUL1: begin
          part  <= v1 - (whole <<< fpgne_pkg::FRAC_W);
          state <= S_MUL2;
        end
        S_MUL2: begin
          hi    <= mul_p;
          state <= S_MUL3;
        end
        S_MUL3: begin
          acc   <= mul_p + 32'(fpgne_pkg::FP_ONE / 2);
          state <= S_MUL4;
        end
        S_MUL4: begin
          res   <= hi + (acc >>> fpgne_pkg::FRAC_W) +
                   $signed(32'(acc[31] && (acc[11:0] != '0)));
          state <= S_DONE;
        end
        S_SIG1: begin
          if (sbig) begin
            res   <= sneg ? 32'sd0 : 32'(fpgne_pkg::FP_ONE);
            state <= S_DONE;
          end else begin
            state <= S_SIG2;
          end
        end
        S_SIG2: begin
          // beyond eight the exp term is zero
          e     <= yabs[15] ? '0 :
                   fpgne_pkg::exp_step(yabs[14:12]) - fpgne_pkg::QUO_W'(mul_p[23:12]);
          state <= S_SIG3;
        end
        S_SIG3: begin
          if (sneg && (e == '0)) begin
            res   <= 32'sd0;
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res   <= 32'(div_quo);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (out_free) begin
            m_tdata  <= res;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second beat taken while a command is in flight");

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the sigmoid wait");

  a_sig_range: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_quo <= fpgne_pkg::QUO_W'(fpgne_pkg::FP_ONE)))
    else $error("sigmoid quotient above one");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DONE))
    else $error("result beat loaded outside the done state");
`endif

endmodule

// File: rtl/fpgne_mul.sv
// Shared 32x32 multiplier with registered low-word product.
module fpgne_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: rtl/fpgne_div.sv
// Iterative radix-2 restoring divider for the sigmoid quotient.
module fpgne_div (
  input  logic                     clk,
  input  logic                     rst,
  input  fpgne_pkg::div_req_t      req,
  output logic                     done,
  output logic [fpgne_pkg::QUO_W-1:0] quo
);

  logic                        busy;
  logic [fpgne_pkg::CNT_W-1:0] cnt;
  logic [fpgne_pkg::DEN_W-1:0] rem;
  logic [fpgne_pkg::DEN_W-1:0] den;
  logic [fpgne_pkg::QUO_W-1:0] nsh;
  logic [fpgne_pkg::DEN_W:0]   trial;
  logic                        ge;

  assign trial = {rem, nsh[fpgne_pkg::QUO_W-1]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= fpgne_pkg::DEN_W'(req.num[fpgne_pkg::NUM_W-1:fpgne_pkg::QUO_W]);
        nsh  <= req.num[fpgne_pkg::QUO_W-1:0];
        den  <= req.den;
        quo  <= '0;
      end else if (busy) begin
        // one quotient bit a cycle
        rem <= ge ? fpgne_pkg::DEN_W'(trial - {1'b0, den}) : fpgne_pkg::DEN_W'(trial);
        quo <= {quo[fpgne_pkg::QUO_W-2:0], ge};
        nsh <= {nsh[fpgne_pkg::QUO_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == fpgne_pkg::CNT_W'(fpgne_pkg::QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: bench/tb_fixed_point_graph_node_executor.sv
// Self-checking testbench of the fixed-point graph node executor, with a shadow variable file.
module tb_fixed_point_graph_node_executor;

  // Op codes above OP_ADD carry no operation and must store zero.
  localparam logic [2:0] OP_UNDEF_LO = 3'd5;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;
  localparam int EXP_TAB [9] = '{4096, 1507, 554, 204, 75, 28, 10, 4, 1};
  localparam int PHASE_ITEMS = 325;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic [1:0]         mode;
    logic [2:0]         op;
    logic [5:0]         first_src;
    logic [5:0]         second_src;
    logic               second_used;
    logic [5:0]         dest;
    logic signed [31:0] write_value;
  } node_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  int shadow_vars [64];
  int pending_values [$];
  int err_count = 0;
  int stall_left = 0;
  bit tx_idle_on = 1'b0;
  bit rx_stall_on = 1'b0;

  fixed_point_graph_node_executor #(.NUM_VARS(64)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // exp(-y) by linear interpolation between integer steps, zero from 8.0 up.
  function automatic int exp_neg_fx(input int y);
    int i;
    int f;
    if (y <= 0) return fpgne_pkg::FP_ONE;
    if (y >= fpgne_pkg::FP_LIMIT) return 0;
    i = y / fpgne_pkg::FP_ONE;
    if (i >= 8) return 0;
    f = y - i * fpgne_pkg::FP_ONE;
    return EXP_TAB[i] + ((EXP_TAB[i+1] - EXP_TAB[i]) * f) / fpgne_pkg::FP_ONE;
  endfunction

  function automatic int sigmoid_fx(input int x);
    int e;
    int d;
    if (x >= fpgne_pkg::FP_LIMIT) return fpgne_pkg::FP_ONE;
    if (x <= -fpgne_pkg::FP_LIMIT) return 0;
    if (x >= 0) begin
      d = fpgne_pkg::FP_ONE + exp_neg_fx(x);
      return (fpgne_pkg::FP_ONE * fpgne_pkg::FP_ONE + d / 2) / d;
    end
    e = exp_neg_fx(-x);
    if (e == 0) return 0;
    d = e + fpgne_pkg::FP_ONE;
    return (e * fpgne_pkg::FP_ONE + d / 2) / d;
  endfunction

  // Split product: whole part times b, plus the rounded fraction part; all wraps at 32 bits.
  function automatic int mul_fx(input int a, input int b);
    int whole;
    int part;
    int hi;
    int inner;
    whole = a / fpgne_pkg::FP_ONE;
    part  = a % fpgne_pkg::FP_ONE;
    hi    = int'(longint'(whole) * longint'(b));
    inner = int'(longint'(part) * longint'(b) + fpgne_pkg::FP_ONE / 2);
    return hi + inner / fpgne_pkg::FP_ONE;
  endfunction

  // Update the shadow file and return the value the block must answer with.
  function automatic int apply_cmd(input node_cmd_t c);
    int v1;
    int v2;
    int res;
    res = 0;
    case (c.mode)
      fpgne_pkg::MODE_WRITE: begin
        shadow_vars[c.dest] = c.write_value;
        res = c.write_value;
      end
      fpgne_pkg::MODE_EXEC: begin
        v1 = shadow_vars[c.first_src];
        v2 = c.second_used ? shadow_vars[c.second_src] : 0;
        case (c.op)
          fpgne_pkg::OP_SIGMOID: res = sigmoid_fx(v1);
          fpgne_pkg::OP_MUL:     res = mul_fx(v1, v2);
          fpgne_pkg::OP_NEG:     res = 0 - v1;
          fpgne_pkg::OP_ADD:     res = v1 + v2;
          default:               res = 0;
        endcase
        shadow_vars[c.dest] = res;
      end
      fpgne_pkg::MODE_READ: res = shadow_vars[c.first_src];
      default:              res = 0;
    endcase
    return res;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (!tx_idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one command beat and hold it until accepted; valid stays high on exit.
  task automatic issue_cmd(input node_cmd_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.mode;
    s_tdata  <= {2'b00, c.write_value, c.dest, c.second_used, c.second_src,
                 c.first_src, c.op};
    do @(posedge clk); while (!s_tready);
    pending_values.push_back(apply_cmd(c));
  endtask

  task automatic do_write(input logic [5:0] idx, input int val);
    node_cmd_t c;
    c = '{fpgne_pkg::MODE_WRITE, 3'($urandom), 6'($urandom), 6'($urandom), 1'($urandom),
          idx, val};
    issue_cmd(c);
  endtask

  task automatic do_read(input logic [5:0] idx);
    node_cmd_t c;
    c = '{fpgne_pkg::MODE_READ, 3'($urandom), idx, 6'($urandom), 1'($urandom),
          6'($urandom), int'($urandom)};
    issue_cmd(c);
  endtask

  task automatic do_exec(input logic [2:0] op, input logic [5:0] a, input logic [5:0] b,
                         input logic used, input logic [5:0] d);
    node_cmd_t c;
    c = '{fpgne_pkg::MODE_EXEC, op, a, b, used, d, int'($urandom)};
    issue_cmd(c);
  endtask

  // Stop sending and wait until every result is back.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_values.size() != 0);
    repeat (24) @(posedge clk);
  endtask

  // Check each result beat against the oldest expectation; shape the stall pattern.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_values.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("unexpected result beat %0d", $signed(m_tdata));
      end else begin
        if (m_tdata !== 32'(pending_values[0])) begin
          err_count++;
          if (err_count <= MAX_SHOWN)
            $display("value mismatch: expected %0d got %0d", pending_values[0],
                     $signed(m_tdata));
        end
        void'(pending_values.pop_front());
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (rx_stall_on && $urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Reset contents, both extremes, the unused mode.
  task automatic test_access_paths();
    node_cmd_t c;
    do_read(6'd5);
    c = '{fpgne_pkg::MODE_IDLE, 3'($urandom), 6'($urandom), 6'($urandom), 1'($urandom),
          6'($urandom), int'($urandom)};
    issue_cmd(c);
    do_write(6'd0, 32'h7FFF_FFFF);
    do_write(6'd63, 32'h8000_0000);
    do_write(6'd1, fpgne_pkg::FP_LIMIT);
    do_write(6'd2, -fpgne_pkg::FP_LIMIT);
    do_write(6'd3, 34816);
    do_write(6'd4, -34816);
    do_write(6'd5, -12411);
  endtask

  // Add, negate, multiply and none, wrap-around, an undefined op code, absent second operand.
  task automatic test_node_ops();
    do_exec(fpgne_pkg::OP_ADD, 6'd0, 6'd0, 1'b1, 6'd10);
    do_exec(fpgne_pkg::OP_NEG, 6'd63, 6'd1, 1'b1, 6'd11);
    do_exec(fpgne_pkg::OP_MUL, 6'd5, 6'd4, 1'b1, 6'd12);
    do_exec(fpgne_pkg::OP_MUL, 6'd0, 6'd63, 1'b1, 6'd13);
    do_exec(fpgne_pkg::OP_NONE, 6'd0, 6'd0, 1'b1, 6'd14);
    do_exec(OP_UNDEF_HI, 6'd0, 6'd0, 1'b1, 6'd15);
    do_exec(fpgne_pkg::OP_ADD, 6'd0, 6'd63, 1'b0, 6'd16);
    do_read(6'd63);
    do_read(6'd12);
  endtask

  // Saturation at +-9.0, the zero-exp band between 8 and 9, zero input, a negative fraction.
  task automatic test_sigmoid_edges();
    do_exec(fpgne_pkg::OP_SIGMOID, 6'd1, 6'd0, 1'b0, 6'd20);
    do_exec(fpgne_pkg::OP_SIGMOID, 6'd2, 6'd0, 1'b0, 6'd21);
    do_exec(fpgne_pkg::OP_SIGMOID, 6'd3, 6'd0, 1'b0, 6'd22);
    do_exec(fpgne_pkg::OP_SIGMOID, 6'd4, 6'd0, 1'b0, 6'd23);
    do_exec(fpgne_pkg::OP_SIGMOID, 6'd5, 6'd0, 1'b0, 6'd24);
    do_exec(fpgne_pkg::OP_SIGMOID, 6'd40, 6'd0, 1'b0, 6'd25);
  endtask

  function automatic logic [5:0] pick_index();
    if ($urandom_range(0, 9) < 7) return 6'($urandom_range(0, 7));
    return 6'($urandom);
  endfunction

  function automatic int pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return int'($urandom);
      default: return int'($urandom_range(0, 163840)) - 81920;
    endcase
  endfunction

  // Random programs: writes into a small working set, node chains over it, read-backs.
  task automatic test_random_programs(input bit idle_on, input bit stall_on);
    node_cmd_t c;
    int r;
    tx_idle_on  = idle_on;
    rx_stall_on = stall_on;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 28) begin
        do_write(pick_index(), pick_value());
      end else if (r < 80) begin
        c = '{fpgne_pkg::MODE_EXEC, 3'($urandom_range(0, 4)), pick_index(), pick_index(),
              1'($urandom_range(0, 5) != 0), pick_index(), int'($urandom)};
        if ($urandom_range(0, 19) == 0) c.op = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        issue_cmd(c);
      end else if (r < 95) begin
        do_read(pick_index());
      end else begin
        c = '{fpgne_pkg::MODE_IDLE, 3'($urandom), 6'($urandom), 6'($urandom), 1'($urandom),
              6'($urandom), int'($urandom)};
        issue_cmd(c);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 64; i++) shadow_vars[i] = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;
    test_access_paths();
    test_node_ops();
    test_sigmoid_edges();
    drain();
    test_random_programs(1'b1, 1'b1);
    drain();
    test_random_programs(1'b0, 1'b0);
    drain();
    test_random_programs(1'b1, 1'b0);
    test_random_programs(1'b0, 1'b1);
    drain();
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
